// ===== hw/rtl/stpt_pkg.sv =====
// Package for the source-type plot transform: payload structs, pipeline
// record and the fixed fraction width. No dependencies.
`default_nettype none
package stpt_pkg;
    localparam int FRAC = 14;
    localparam int MW   = FRAC + 2;

    typedef struct packed {
        logic signed [15:0] t_value;
        logic signed [15:0] k_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               out_of_range;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_FLAG  = 2'd0,
        CLS_OPP   = 2'd1,
        CLS_KONE  = 2'd2,
        CLS_SAME  = 2'd3
    } t_cls;

    // classified item: magnitudes and signs
    typedef struct packed {
        t_cls          cls;
        logic [MW-1:0] at;
        logic [MW-1:0] ak;
        logic          xneg;
        logic          yneg;
    } t_cls_item;

    function automatic logic [15:0] sat_sign(input logic [63:0] mag, input logic neg);
        logic [15:0] m;
        begin
            if (neg) begin
                m = (mag > 64'd32768) ? 16'h8000 : 16'(0 - mag[15:0]);
            end else begin
                m = (mag > 64'd32767) ? 16'h7fff : mag[15:0];
            end
            return m;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/stpt_front.sv =====
// Front end: takes (T, k), range checks and classifies into quadrant cases.
// Depends on stpt_pkg.
`default_nettype none
module stpt_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  stpt_pkg::t_in_item     i_item,
    output logic                   o_valid,
    input  wire                    i_ready,
    output stpt_pkg::t_cls_item    o_item
);
    import stpt_pkg::*;
    localparam logic [MW-1:0] ONE = MW'(1) << FRAC;

    logic [MW-1:0] at, ak;
    logic signed [15:0] t, k;
    t_cls_item c;
    logic r_v;
    t_cls_item r_item;

    always_comb begin
        t  = i_item.t_value;
        k  = i_item.k_value;
        at = t[15] ? MW'(17'(0 - {t[15], t})) : MW'(t);
        ak = k[15] ? MW'(17'(0 - {k[15], k})) : MW'(k);
        c.at = at;
        c.ak = ak;
        c.yneg = k[15];
        c.xneg = t[15];
        if ((17'(at) > 17'(ONE)) || (17'(ak) > 17'(ONE)) ||
            (t[15] && 16'(0 - t) == 16'h8000 && FRAC < 15) ||
            (k[15] && 16'(0 - k) == 16'h8000 && FRAC < 15)) begin
            c.cls = CLS_FLAG;
        end else begin
            if (at == ONE && ak == ONE) begin
                c.at = '0;
                c.xneg = 1'b0;
            end
            if (c.at == '0 || ak == '0 || (c.xneg != c.yneg)) begin
                c.cls = CLS_OPP;
            end else if (ak == ONE) begin
                c.cls = CLS_KONE;
            end else begin
                c.cls = CLS_SAME;
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= c;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/stpt_fifo.sv =====
// Two-entry queue of classified items between front and back.
// Depends on stpt_pkg.
`default_nettype none
module stpt_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  stpt_pkg::t_cls_item    i_item,
    output logic                   o_valid,
    input  wire                    i_ready,
    output stpt_pkg::t_cls_item    o_item
);
    import stpt_pkg::*;
    t_cls_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/stpt_back.sv =====
// Back end: pipelined arithmetic, one item per cycle unless stalled.
// Stages: u, |x| division setup, 8 |x| divide steps, |y| and region test,
// 8 second-region divide steps, second-region |x|. Depends on stpt_pkg.
`default_nettype none
module stpt_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  stpt_pkg::t_cls_item    i_item,
    output logic                   o_valid,
    input  wire                    i_ready,
    output stpt_pkg::t_out_item    o_item
);
    import stpt_pkg::*;
    localparam int QB  = 16;
    localparam int BPS = 2;
    localparam int DS  = QB / BPS;
    localparam int D1  = 2;
    localparam int X1  = D1 + DS;
    localparam int D2  = X1 + 1;
    localparam int X2  = D2 + DS;
    localparam int NS  = X2 + 1;
    localparam int QW  = 2 * MW + 4;
    localparam logic [MW+1:0] ONE = (MW+2)'(1) << FRAC;

    // per-stage payload
    typedef struct packed {
        t_cls          cls;
        logic [MW-1:0] at;
        logic [MW-1:0] ak;
        logic          xneg;
        logic          yneg;
        logic [MW+1:0] u;
        logic [MW+3:0] xm;
        logic [MW+3:0] ym;
        logic          r2;
        logic [QW-1:0] rem;
        logic [MW+3:0] den;
        logic [QB-1:0] q;
    } t_st;

    logic    [NS-1:0] r_v;
    t_st     r_s [NS];
    t_st     n_s [NS];
    logic    adv;
    t_out_item r_out;
    logic    r_ov;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    // restoring divide, BPS quotient bits per stage starting at bit hi;
    // the numerator already carries the rounding term
    function automatic t_st div_step(input t_st s, input int hi);
        t_st r;
        logic [QW-1:0] sub;
        r = s;
        for (int j = 0; j < BPS; j++) begin
            sub = QW'(s.den) << (hi - j);
            if (r.rem >= sub) begin
                r.rem = r.rem - sub;
                r.q[hi - j] = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb begin
        logic [QW-1:0] p;
        logic [QW-1:0] x2;
        logic [MW+3:0] d;
        p  = '0;
        x2 = '0;
        d  = '0;
        // u
        n_s[0]      = '0;
        n_s[0].cls  = i_item.cls;
        n_s[0].at   = i_item.at;
        n_s[0].ak   = i_item.ak;
        n_s[0].xneg = i_item.xneg;
        n_s[0].yneg = i_item.yneg;
        p = QW'(i_item.at) * QW'(ONE - (MW+2)'(i_item.ak));
        n_s[0].u = (MW+2)'((p + QW'(ONE >> 1)) >> FRAC);
        // |x| division setup (same) or final (opp)
        n_s[1] = r_s[0];
        n_s[1].ym = (MW+4)'(r_s[0].ak);
        if (r_s[0].cls == CLS_SAME) begin
            d = (MW+4)'(ONE << 1) - (MW+4)'(r_s[0].u);
            n_s[1].den = d;
            n_s[1].rem = (QW'(r_s[0].u) << (FRAC + 1)) + QW'(d >> 1);
            n_s[1].q   = '0;
        end else if (r_s[0].cls == CLS_OPP) begin
            n_s[1].xm = (MW+4)'(r_s[0].u);
        end else begin
            n_s[1].xm = '0;
        end
        for (int i = 0; i < DS; i++) begin
            n_s[D1 + i] = div_step(r_s[D1 + i - 1], QB - 1 - i * BPS);
        end
        // |y|, region test, second-region division setup
        n_s[X1] = r_s[X1 - 1];
        if (r_s[X1 - 1].cls == CLS_SAME) begin
            n_s[X1].xm = (MW+4)'(r_s[X1 - 1].q);
            p = QW'(r_s[X1 - 1].ak) *
                QW'((MW+4)'(ONE << 1) + (MW+4)'(r_s[X1 - 1].q));
            n_s[X1].ym = (MW+4)'((p + QW'(ONE)) >> (FRAC + 1));
            n_s[X1].r2 = (r_s[X1 - 1].q != '0) &&
                         (((MW+6)'(n_s[X1].ym) << 2) < (MW+6)'(r_s[X1 - 1].q));
        end
        d = ((MW+4)'(ONE) > ((MW+4)'(r_s[X1 - 1].ak) << 1)) ?
            (MW+4)'(ONE) - ((MW+4)'(r_s[X1 - 1].ak) << 1) : (MW+4)'(1);
        n_s[X1].den = d;
        n_s[X1].rem = (QW'(r_s[X1 - 1].ak) << FRAC) + QW'(d >> 1);
        n_s[X1].q   = '0;
        for (int i = 0; i < DS; i++) begin
            n_s[D2 + i] = div_step(r_s[D2 + i - 1], QB - 1 - i * BPS);
        end
        // second-region |y| and |x|
        n_s[X2] = r_s[X2 - 1];
        if (r_s[X2 - 1].r2) begin
            n_s[X2].ym = (MW+4)'(r_s[X2 - 1].q);
            p  = QW'(r_s[X2 - 1].at) * QW'((MW+4)'(ONE) + (MW+4)'(r_s[X2 - 1].q));
            x2 = (p + QW'(ONE >> 1)) >> FRAC;
            n_s[X2].xm = (x2 > QW'({(MW+4){1'b1}})) ? {(MW+4){1'b1}} : x2[MW+3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                r_s[i] <= n_s[i];
            end
            if (r_s[NS-1].cls == CLS_FLAG) begin
                r_out.x_coord      <= '0;
                r_out.y_coord      <= '0;
                r_out.out_of_range <= 1'b1;
            end else begin
                r_out.x_coord      <= sat_sign(64'(r_s[NS-1].xm), r_s[NS-1].xneg);
                r_out.y_coord      <= sat_sign(64'(r_s[NS-1].ym), r_s[NS-1].yneg);
                r_out.out_of_range <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/source_type_plot_transform.sv =====
// Top level of the (T, k) source-type plot transform.
// Instantiates stpt_front, stpt_fifo and stpt_back; depends on stpt_pkg.
//
// One (T, k) pair in, one (x, y, flag) item out, one pair per cycle sustained
// while the output is not stalled. From acceptance to o_valid an item passes
// the front register, the queue, twenty arithmetic stages and the output
// register. The depth is set by the two rounded divisions, each a restoring
// divide of 16 quotient bits at two bits per stage (8 stages each). The whole
// back pipeline advances only when its output register is free or being taken.
`default_nettype none
module source_type_plot_transform (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  stpt_pkg::t_in_item      i_item,
    output logic                    o_valid,
    input  wire                     i_ready,
    output stpt_pkg::t_out_item     o_item
);
    import stpt_pkg::*;
    t_cls_item f_item, q_item;
    logic f_v, f_r, q_v, q_r;

    stpt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_valid(f_v), .i_ready(f_r), .o_item(f_item)
    );
    stpt_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_item(f_item),
        .o_valid(q_v), .i_ready(q_r), .o_item(q_item)
    );
    stpt_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_item(q_item),
        .o_valid, .i_ready, .o_item
    );
endmodule
`default_nettype wire

// ===== hw/rtl/stpt_checker.sv =====
// Port-level checker for source_type_plot_transform, bound to the top level.
// Depends on stpt_pkg.
`default_nettype none
module stpt_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_valid,
    input wire                  i_ready,
    input stpt_pkg::t_out_item  o_item
);
    import stpt_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("out hold");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.out_of_range |-> o_item.x_coord == '0 && o_item.y_coord == '0)
        else $error("flag zero");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("reset valid");
endmodule

bind source_type_plot_transform stpt_checker u_chk (.*);
`default_nettype wire
